/* rtl/olt_pkg.sv */
package olt_pkg;

  // Default number of list entries.
  localparam int DEPTH_DEF = 32;

  // Fixed field widths of the command and result channels.
  localparam int OP_W    = 4;
  localparam int POS_W   = 6;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = 6;
  localparam int CAP_W   = 6;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  // Index and count width carried to the cells; covers lists of up to 511 entries.
  localparam int CELL_IW = 9;

  // Command codes on the input channel.
  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_INS_AT    = 4'd2,
    OP_REM_FRONT = 4'd3,
    OP_REM_BACK  = 4'd4,
    OP_REM_AT    = 4'd5,
    OP_SEARCH    = 4'd6,
    OP_SELECT    = 4'd7,
    OP_REPLACE   = 4'd8
  } op_t;

  // Operation that every cell carries out.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_REM,
    CELL_PUT,
    CELL_FIND,
    CELL_PICK
  } cell_cmd_t;

  // Control broadcast from the sequencer to the row of cells.
  typedef struct packed {
    cell_cmd_t          cmd;
    logic [CELL_IW-1:0] idx;
    logic [CELL_IW-1:0] cnt;
    logic [VALUE_W-1:0] value;
  } cell_ctl_t;

endpackage

/* rtl/olt_cell.sv */
module olt_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  olt_pkg::cell_ctl_t           ctl,
  input  logic [olt_pkg::VALUE_W-1:0]  lower_data,
  input  logic [olt_pkg::VALUE_W-1:0]  upper_data,
  output logic [olt_pkg::VALUE_W-1:0]  data,
  output logic                         hit,
  output logic [olt_pkg::VALUE_W-1:0]  pick
);

  localparam logic [olt_pkg::CELL_IW-1:0] MyIdx = olt_pkg::CELL_IW'(IDX);

  logic [olt_pkg::VALUE_W-1:0] data_r, data_nxt;
  logic                        hit_r, hit_nxt;
  logic [olt_pkg::VALUE_W-1:0] pick_r, pick_nxt;

  // Next entry value: shift from a neighbor, take the broadcast word, or hold.
  // The match flag and the picked word hold until the next compare or pick, so a
  // result that waits for the output register still sees them.
  always_comb begin
    data_nxt = data_r;
    hit_nxt  = hit_r;
    pick_nxt = pick_r;
    case (ctl.cmd)
      olt_pkg::CELL_INS: begin
        if (MyIdx > ctl.idx) begin
          data_nxt = lower_data;
        end else if (MyIdx == ctl.idx) begin
          data_nxt = ctl.value;
        end
      end
      olt_pkg::CELL_REM: begin
        if (MyIdx >= ctl.idx) begin
          data_nxt = upper_data;
        end
      end
      olt_pkg::CELL_PUT: begin
        if (MyIdx == ctl.idx) begin
          data_nxt = ctl.value;
        end
      end
      olt_pkg::CELL_FIND: begin
        hit_nxt = (MyIdx < ctl.cnt) && (data_r == ctl.value);
      end
      olt_pkg::CELL_PICK: begin
        pick_nxt = (MyIdx == ctl.idx) ? data_r : '0;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // Entry and per-cell result registers; the entry needs no reset.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    hit_r  <= hit_nxt;
    pick_r <= pick_nxt;
  end

  assign data = data_r;
  assign hit  = hit_r;
  assign pick = pick_r;

endmodule

/* rtl/ordered_list_table.sv */
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | in_operation, in_position, in_value
// out_    | output    | out_valid/out_stall| out_ok, out_found_index, out_read_value,
//         |           |                    | out_count, out_is_empty, out_is_full
// cfg_    | input     | cfg_valid/cfg_ready| cfg_capacity_limit
//
// A command is accepted only in the idle state, once the previous one has left its
// final step. After the input transfer it runs through the execute step, in which the
// row of cells shifts, writes or compares, and then the final step, which encodes the
// search index and loads the output register. A new command is taken while the
// previous result still waits; if it is stalled, the block holds in its final step.
// Reset is synchronous, clears the count and handshake state, and sets capacity to 32.
module ordered_list_table #(
  parameter int DEPTH = olt_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [olt_pkg::OP_W-1:0]            in_operation,
  input  logic [olt_pkg::POS_W-1:0]           in_position,
  input  logic signed [olt_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_ok,
  output logic [olt_pkg::CNT_W-1:0]           out_found_index,
  output logic signed [olt_pkg::VALUE_W-1:0]  out_read_value,
  output logic [olt_pkg::CNT_W-1:0]           out_count,
  output logic                                out_is_empty,
  output logic                                out_is_full,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [olt_pkg::CAP_W-1:0]           cfg_capacity_limit
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > olt_pkg::POS_W) ? CW : olt_pkg::POS_W) + 1;
  localparam int VW = olt_pkg::VALUE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } state_t;

  state_t                       state_r;
  logic [olt_pkg::OP_W-1:0]     op_r;
  logic [olt_pkg::POS_W-1:0]    pos_r;
  logic [VW-1:0]                val_r;
  logic [CW-1:0]                count_r, count_nxt;
  logic [olt_pkg::CAP_W-1:0]    cap_r;
  logic                         ok_r, ok_nxt;

  logic                         out_valid_r;
  logic                         out_ok_r;
  logic [olt_pkg::CNT_W-1:0]    out_found_r, found_nxt;
  logic [VW-1:0]                out_rd_r, rd_nxt;
  logic [olt_pkg::CNT_W-1:0]    out_count_r;
  logic                         out_empty_r;
  logic                         out_full_r;

  logic [XW-1:0]                cnt_x, pos_x, cap_x, ins_pos_x, rem_pos_x, sel_x;
  logic                         is_ins, is_rem, full_now, ins_ok, rem_ok, rep_ok;
  olt_pkg::cell_ctl_t           ctl;

  logic [VW-1:0]                cell_data [DEPTH];
  logic [VW-1:0]                cell_pick [DEPTH];
  logic [DEPTH-1:0]             cell_hit;
  logic [DEPTH-1:0]             hit_first;
  logic [IW-1:0]                hit_idx;
  logic [VW-1:0]                pick_any;
  logic                         in_xfer, out_free;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Effective capacity: the register clamped to 1..DEPTH.
  always_comb begin
    cap_x = XW'(cap_r);
    if (cap_r == '0) begin
      cap_x = XW'(1);
    end else if (XW'(cap_r) > XW'(DEPTH)) begin
      cap_x = XW'(DEPTH);
    end
  end

  assign cnt_x    = XW'(count_r);
  assign pos_x    = XW'(pos_r);
  assign full_now = cnt_x >= cap_x;

  // Decide the command outcome from the registered command and the count.
  always_comb begin
    is_ins    = 1'b0;
    is_rem    = 1'b0;
    ins_pos_x = '0;
    rem_pos_x = '0;
    case (op_r)
      olt_pkg::OP_INS_FRONT: begin
        is_ins = 1'b1;
      end
      olt_pkg::OP_INS_BACK: begin
        is_ins    = 1'b1;
        ins_pos_x = cnt_x;
      end
      olt_pkg::OP_INS_AT: begin
        is_ins    = 1'b1;
        ins_pos_x = pos_x;
      end
      olt_pkg::OP_REM_FRONT: begin
        is_rem = 1'b1;
      end
      olt_pkg::OP_REM_BACK: begin
        is_rem    = 1'b1;
        rem_pos_x = cnt_x - XW'(1);
      end
      olt_pkg::OP_REM_AT: begin
        is_rem    = 1'b1;
        rem_pos_x = pos_x;
      end
      default: begin
        is_ins = 1'b0;
      end
    endcase
  end

  assign ins_ok = is_ins && !full_now && (ins_pos_x <= cnt_x) && (cnt_x < XW'(DEPTH));
  assign rem_ok = is_rem && (count_r != '0) && (rem_pos_x < cnt_x);
  assign rep_ok = (op_r == olt_pkg::OP_REPLACE) && (pos_x < cnt_x);
  assign sel_x  = (pos_x >= cnt_x) ? (cnt_x - XW'(1)) : pos_x;

  // Broadcast to the cells, active only in the execute step.
  always_comb begin
    ctl.cmd   = olt_pkg::CELL_HOLD;
    ctl.idx   = '0;
    ctl.cnt   = olt_pkg::CELL_IW'(count_r);
    ctl.value = val_r;
    ok_nxt    = 1'b0;
    count_nxt = count_r;
    if (state_r == ST_EXEC) begin
      if (ins_ok) begin
        ctl.cmd   = olt_pkg::CELL_INS;
        ctl.idx   = olt_pkg::CELL_IW'(ins_pos_x);
        ok_nxt    = 1'b1;
        count_nxt = count_r + CW'(1);
      end else if (rem_ok) begin
        ctl.cmd   = olt_pkg::CELL_REM;
        ctl.idx   = olt_pkg::CELL_IW'(rem_pos_x);
        ok_nxt    = 1'b1;
        count_nxt = count_r - CW'(1);
      end else if (rep_ok) begin
        ctl.cmd = olt_pkg::CELL_PUT;
        ctl.idx = olt_pkg::CELL_IW'(pos_x);
        ok_nxt  = 1'b1;
      end else if (op_r == olt_pkg::OP_SEARCH) begin
        ctl.cmd = olt_pkg::CELL_FIND;
      end else if (op_r == olt_pkg::OP_SELECT) begin
        ctl.cmd = olt_pkg::CELL_PICK;
        ctl.idx = olt_pkg::CELL_IW'(sel_x);
      end
    end
  end

  // The row of cells; each passes its entry to both neighbors.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VW-1:0] lower, upper;
    if (g == 0) begin : g_lo_end
      assign lower = '0;
    end else begin : g_lo
      assign lower = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_up_end
      assign upper = '0;
    end else begin : g_up
      assign upper = cell_data[g+1];
    end
    olt_cell #(
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .lower_data (lower),
      .upper_data (upper),
      .data       (cell_data[g]),
      .hit        (cell_hit[g]),
      .pick       (cell_pick[g])
    );
  end

  // Lowest matching cell, then its index; the picked word is the OR of all cells.
  assign hit_first = cell_hit & (~cell_hit + DEPTH'(1));

  always_comb begin
    hit_idx  = '0;
    pick_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_first[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
      pick_any = pick_any | cell_pick[i];
    end
  end

  // Result fields for the final step.
  always_comb begin
    found_nxt = '0;
    rd_nxt    = '0;
    if (op_r == olt_pkg::OP_SEARCH) begin
      found_nxt = (cell_hit != '0) ? olt_pkg::CNT_W'(hit_idx) : olt_pkg::CNT_W'(count_r);
    end
    if (op_r == olt_pkg::OP_SELECT) begin
      rd_nxt = (count_r == '0) ? '1 : pick_any;
    end
  end

  // Sequencer, count, capacity and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= olt_pkg::CAP_RESET;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity_limit;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          count_r <= count_nxt;
          ok_r    <= ok_nxt;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_operation;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (state_r == ST_FIN && out_free) begin
      out_ok_r    <= ok_r;
      out_found_r <= found_nxt;
      out_rd_r    <= rd_nxt;
      out_count_r <= olt_pkg::CNT_W'(count_r);
      out_empty_r <= (count_r == '0);
      out_full_r  <= full_now;
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_found_index = out_found_r;
  assign out_read_value  = out_rd_r;
  assign out_count       = out_count_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;

endmodule

/* rtl/olt_checker.sv */
module olt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [olt_pkg::CNT_W-1:0]          out_count,
  input logic                               out_is_empty,
  input logic                               out_is_full
);

  // A result that is stalled stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // After a command transfer the block is busy for the next cycle.
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("command taken while the previous one runs");

  // Empty flag agrees with the reported count.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)))
    else $error("empty flag does not match count");

  // Capacity is at least one, so a list cannot be both empty and full.
  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_empty && out_is_full))
    else $error("list reported empty and full");

endmodule

bind ordered_list_table olt_checker u_olt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_count    (out_count),
  .out_is_empty (out_is_empty),
  .out_is_full  (out_is_full)
);

/* verif/ordered_list_table_check.sv */
import olt_pkg::*;

module ordered_list_table_check #(
  parameter int DEPTH = olt_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [OP_W-1:0]            in_operation,
  input  logic [POS_W-1:0]           in_position,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_ok,
  input  logic [CNT_W-1:0]           out_found_index,
  input  logic signed [VALUE_W-1:0]  out_read_value,
  input  logic [CNT_W-1:0]           out_count,
  input  logic                       out_is_empty,
  input  logic                       out_is_full,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CAP_W-1:0]           cfg_capacity_limit,
  output int                         fail_count,
  output int                         pending
);

  // One result of a list command, in the order of the result ports.
  typedef struct packed {
    logic                      ok;
    logic [CNT_W-1:0]          found_index;
    logic signed [VALUE_W-1:0] read_value;
    logic [CNT_W-1:0]          count;
    logic                      is_empty;
    logic                      is_full;
  } list_result_t;

  // Shadow copy of the list contents, the fill level and the capacity register.
  logic signed [VALUE_W-1:0] list_words [DEPTH];
  int                        list_len = 0;
  logic [CAP_W-1:0]          capacity_reg = CAP_RESET;
  list_result_t              awaited_results [$];
  int                        errs = 0;

  // The register value is clamped to 1..DEPTH; a list at or above it is full.
  function automatic bit list_at_limit();
    int lim;
    lim = capacity_reg;
    if (lim < 1) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    return list_len >= lim;
  endfunction

  // Open a slot at the given index; the words above it move up by one.
  function automatic bit list_insert(int idx, logic signed [VALUE_W-1:0] word);
    if (list_at_limit() || idx > list_len || list_len >= DEPTH) return 1'b0;
    for (int i = list_len; i > idx; i--) list_words[i] = list_words[i-1];
    list_words[idx] = word;
    list_len++;
    return 1'b1;
  endfunction

  // Close the slot at the given index; the words above it move down by one.
  function automatic bit list_remove(int idx);
    if (list_len == 0 || idx >= list_len) return 1'b0;
    for (int i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
    list_len--;
    return 1'b1;
  endfunction

  // Run one command on the shadow list and return what the block must report.
  function automatic list_result_t run_list_cmd(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                                logic signed [VALUE_W-1:0] word);
    list_result_t res;
    int idx;
    res = '0;
    idx = pos;
    case (op)
      OP_INS_FRONT: res.ok = list_insert(0, word);
      OP_INS_BACK:  res.ok = list_insert(list_len, word);
      OP_INS_AT:    res.ok = list_insert(idx, word);
      OP_REM_FRONT: res.ok = list_remove(0);
      OP_REM_BACK:  res.ok = (list_len != 0) ? list_remove(list_len - 1) : 1'b0;
      OP_REM_AT:    res.ok = list_remove(idx);
      OP_SEARCH: begin
        res.found_index = CNT_W'(list_len);
        for (int i = 0; i < list_len; i++) begin
          if (list_words[i] == word) begin
            res.found_index = CNT_W'(i);
            break;
          end
        end
      end
      OP_SELECT: begin
        if (list_len == 0) res.read_value = -1;
        else if (idx >= list_len) res.read_value = list_words[list_len-1];
        else res.read_value = list_words[idx];
      end
      OP_REPLACE: begin
        if (idx < list_len) begin
          list_words[idx] = word;
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(list_len);
    res.is_empty = (list_len == 0);
    res.is_full = list_at_limit();
    return res;
  endfunction

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      errs++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Watch all three channels at each rising edge; predict on input transfers and
  // compare each result transfer against the oldest prediction.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      list_len = 0;
      capacity_reg = CAP_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) capacity_reg = cfg_capacity_limit;
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          errs++;
          $error("result transfer with no command outstanding");
        end else begin
          want = awaited_results.pop_front();
          compare_field("out_ok", want.ok, out_ok);
          compare_field("out_found_index", want.found_index, out_found_index);
          compare_field("out_read_value", want.read_value, out_read_value);
          compare_field("out_count", want.count, out_count);
          compare_field("out_is_empty", want.is_empty, out_is_empty);
          compare_field("out_is_full", want.is_full, out_is_full);
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(run_list_cmd(in_operation, in_position, in_value));
    end
    pending <= awaited_results.size();
    fail_count <= errs;
  end

endmodule

/* verif/ordered_list_table_test.sv */
import olt_pkg::*;

module ordered_list_table_test;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [OP_W-1:0]            in_operation = '0;
  logic [POS_W-1:0]           in_position = '0;
  logic signed [VALUE_W-1:0]  in_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_ok;
  logic [CNT_W-1:0]           out_found_index;
  logic signed [VALUE_W-1:0]  out_read_value;
  logic [CNT_W-1:0]           out_count;
  logic                       out_is_empty;
  logic                       out_is_full;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CAP_W-1:0]           cfg_capacity_limit = '0;
  int                         fail_count;
  int                         pending;
  int                         burst_left = 0;
  int                         stall_mode = 0;
  int                         stall_span = 0;

  always #4 clk = ~clk;

  ordered_list_table dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ok             (out_ok),
    .out_found_index    (out_found_index),
    .out_read_value     (out_read_value),
    .out_count          (out_count),
    .out_is_empty       (out_is_empty),
    .out_is_full        (out_is_full),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity_limit (cfg_capacity_limit)
  );

  ordered_list_table_check checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ok             (out_ok),
    .out_found_index    (out_found_index),
    .out_read_value     (out_read_value),
    .out_count          (out_count),
    .out_is_empty       (out_is_empty),
    .out_is_full        (out_is_full),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity_limit (cfg_capacity_limit),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // The result side alternates between calm stretches, light stalls and heavy stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_span <= 0;
    end else if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(10, 60);
      out_stall <= 1'b0;
    end else begin
      stall_span <= stall_span - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Offer one command; commands go out in bursts with idle gaps in between.
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic signed [VALUE_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_operation <= op;
    in_position <= pos;
    in_value <= word;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold the input channel idle until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_capacity_limit <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Values mostly come from a small pool so that searches hit.
  function automatic logic signed [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      6: return 32'h7fff_ffff;
      7: return 32'h8000_0000;
      8: return -1;
      9: return $urandom;
      default: return $urandom_range(0, 5);
    endcase
  endfunction

  // Weighted choice of command class; a few unused codes are mixed in.
  function automatic logic [OP_W-1:0] pick_op(int ins_pct, int rem_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) return OP_W'($urandom_range(OP_INS_FRONT, OP_INS_AT));
    if (roll < ins_pct + rem_pct) return OP_W'($urandom_range(OP_REM_FRONT, OP_REM_AT));
    if (roll < 97) return OP_W'($urandom_range(OP_SEARCH, OP_REPLACE));
    return OP_W'($urandom_range(int'(OP_REPLACE) + 1, (1 << OP_W) - 1));
  endfunction

  initial begin
    int cap_plan [8] = '{32, 3, 0, 63, 1, 9, 2, 32};
    int ins_plan [8] = '{55, 40, 45, 55, 40, 45, 35, 25};
    int rem_plan [8] = '{20, 30, 25, 20, 30, 25, 25, 50};
    logic [POS_W-1:0] pos;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list corners, index limits, extreme values, unused codes.
    send_cmd(OP_SELECT, 0, 0);
    send_cmd(OP_REM_FRONT, 0, 0);
    send_cmd(OP_REM_BACK, 63, 0);
    send_cmd(OP_REM_AT, 0, 0);
    send_cmd(OP_REPLACE, 0, 7);
    send_cmd(OP_SEARCH, 0, 0);
    send_cmd(OP_INS_AT, 1, 9);
    send_cmd(OP_INS_AT, 0, 32'h7fff_ffff);
    send_cmd(OP_INS_FRONT, 63, 32'h8000_0000);
    send_cmd(OP_INS_BACK, 0, -1);
    send_cmd(OP_INS_AT, 3, 0);
    send_cmd(OP_INS_AT, 2, 5);
    send_cmd(OP_INS_AT, 63, 1);
    send_cmd(OP_SEARCH, 0, 5);
    send_cmd(OP_SEARCH, 0, 123);
    send_cmd(OP_SELECT, 63, 0);
    send_cmd(OP_SELECT, 0, 0);
    send_cmd(OP_REPLACE, 5, 3);
    send_cmd(OP_REPLACE, 4, 32'h5555_5555);
    send_cmd(OP_REM_AT, 63, 0);
    send_cmd(OP_REM_AT, 1, 0);
    send_cmd(OP_REM_FRONT, 0, 0);
    send_cmd(OP_REM_BACK, 0, 0);
    send_cmd(OP_W'(int'(OP_REPLACE) + 1), 63, -1);
    send_cmd(OP_W'((1 << OP_W) - 1), 0, 32'h8000_0000);

    // Random phases, each under its own capacity; the list keeps its contents
    // across phases, so a smaller capacity can land below the current count.
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      write_capacity(CAP_W'(cap_plan[ph]));
      for (int n = 0; n < 230; n++) begin
        pos = ($urandom_range(0, 7) == 0) ? POS_W'($urandom_range(0, 63))
                                          : POS_W'($urandom_range(0, 33));
        send_cmd(pick_op(ins_plan[ph], rem_plan[ph]), pos, pick_word());
      end
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
rtl/olt_pkg.sv
rtl/olt_cell.sv
rtl/ordered_list_table.sv
rtl/olt_checker.sv
verif/ordered_list_table_check.sv
verif/ordered_list_table_test.sv
